### rtl/core/cell_balance_select_macros.svh
// ----------------------------------------------------------------------------
// cell_balance_select_macros.svh
// assertion helpers shared by the cell balancing rtl
// ----------------------------------------------------------------------------
`ifndef CELL_BALANCE_SELECT_MACROS_SVH
`define CELL_BALANCE_SELECT_MACROS_SVH

// clocked check, quiet while reset is held
`define CBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define CBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// shared types, widths and constants for the cell balancing selector
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

    localparam int CELL_COUNT = 6;
    localparam int MV_W       = 13;
    localparam int TEMP_W     = 8;

    typedef logic        [MV_W-1:0]   t_mv;
    typedef logic signed [TEMP_W-1:0] t_temp;

    // search for the lowest cell starts here
    localparam t_mv MIN_SEARCH_START_MV = 13'd5000;

    // register reset values
    localparam t_temp RST_TEMP_LOW  = 8'sd0;
    localparam t_temp RST_TEMP_HIGH = 8'sd45;
    localparam t_mv   RST_DIFF_MV   = 13'd20;
    localparam t_mv   RST_START_MV  = 13'd3400;

    // register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_TEMP_LOW  = 2'd0,
        REG_TEMP_HIGH = 2'd1,
        REG_DIFF_MV   = 2'd2,
        REG_START_MV  = 2'd3
    } t_reg_idx;

    // thresholds seen by every lane
    typedef struct packed {
        t_mv diff_mv;
        t_mv start_mv;
    } t_lane_cfg;

    function automatic t_mv min_mv(input t_mv a, input t_mv b);
        min_mv = (b < a) ? b : a;
    endfunction

endpackage

`default_nettype wire

### rtl/core/cbs_lane.sv
// ----------------------------------------------------------------------------
// cbs_lane
// candidate test for one cell against the pack minimum and thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_lane
    import cbs_pkg::*;
(
    input  wire t_mv       i_cell_mv,
    input  wire t_mv       i_lowest_mv,
    input  wire            i_temp_ok,
    input  wire t_lane_cfg i_cfg,
    output logic           o_cand
);

    t_mv excess;

    // lowest never exceeds any cell, so the excess cannot wrap
    assign excess = i_cell_mv - i_lowest_mv;

    assign o_cand = i_temp_ok && (excess >= i_cfg.diff_mv) && (i_cell_mv >= i_cfg.start_mv);

endmodule

`default_nettype wire

### rtl/core/cbs_merge.sv
// ----------------------------------------------------------------------------
// cbs_merge
// thins adjacent candidates and packs the balance register bytes
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_merge
    import cbs_pkg::*;
(
    input  wire t_mv                   i_cells [CELL_COUNT],
    input  wire  [CELL_COUNT-1:0]      i_cand,
    output logic [CELL_COUNT-1:0]      o_mask,
    output logic [7:0]                 o_bank1,
    output logic [7:0]                 o_bank2
);

    // walk pairs from the bottom, a drop is seen by the next pair
    always_comb begin
        logic [CELL_COUNT-1:0] c;
        c = i_cand;
        for (int i = 0; i < CELL_COUNT - 1; i++) begin
            if (c[i] && c[i+1]) begin
                if (i_cells[i] < i_cells[i+1]) begin
                    c[i] = 1'b0;
                end else begin
                    c[i+1] = 1'b0;
                end
            end
        end
        o_mask = c;
    end

    // balance bytes use bits 0, 1 and 4
    assign o_bank1 = {3'b000, o_mask[2], 2'b00, o_mask[1], o_mask[0]};
    assign o_bank2 = {3'b000, o_mask[5], 2'b00, o_mask[4], o_mask[3]};

endmodule

`default_nettype wire

### rtl/core/cell_balance_select.sv
// ----------------------------------------------------------------------------
// cell_balance_select
// passive balancing selection for a six-cell pack
// ----------------------------------------------------------------------------
// Input stream: one item per handshake carries six cell voltages and the
// pack temperature. Output stream: one item per input with the balance
// mask, the two balance register bytes and the lowest cell voltage.
// There are two register stages: an accepted item is held in the
// first stage, then moves to the output register. The first stage holds
// the cells with the lowest voltage from a compare tree, the second holds
// the result of six parallel candidate lanes and the pair thinning chain.
// Throughput is one item per cycle while the receiver keeps tready high.
// When the receiver stalls the output register holds its item and the
// first stage can still take one more item before tready drops.
// Reset clears both stage valids and loads the register defaults
// (window 0..45 C, 20 mV difference, 3400 mV start). Registers are
// written over the APB port, pready is always high, reads return the
// register value zero extended.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_balance_select
    import cbs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // apb configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata from bit 0: cell0_mv[13], cell1_mv[13], cell2_mv[13],
    // cell3_mv[13], cell4_mv[13], cell5_mv[13], pack_temp_c[8], pad[2]
    input  wire  [87:0] i_s_axis_tdata,
    // output stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // tdata from bit 0: balance_mask[6], bank1_bits[8], bank2_bits[8],
    // lowest_mv[13], pad[5]
    output logic [39:0] o_m_axis_tdata
);

    // configuration registers
    t_temp r_temp_low;
    t_temp r_temp_high;
    t_mv   r_diff_mv;
    t_mv   r_start_mv;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low  <= RST_TEMP_LOW;
            r_temp_high <= RST_TEMP_HIGH;
            r_diff_mv   <= RST_DIFF_MV;
            r_start_mv  <= RST_START_MV;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TEMP_LOW:  r_temp_low  <= t_temp'(pwdata[TEMP_W-1:0]);
                REG_TEMP_HIGH: r_temp_high <= t_temp'(pwdata[TEMP_W-1:0]);
                REG_DIFF_MV:   r_diff_mv   <= pwdata[MV_W-1:0];
                REG_START_MV:  r_start_mv  <= pwdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_TEMP_LOW:  prdata = {24'd0, r_temp_low};
            REG_TEMP_HIGH: prdata = {24'd0, r_temp_high};
            REG_DIFF_MV:   prdata = {19'd0, r_diff_mv};
            REG_START_MV:  prdata = {19'd0, r_start_mv};
            default:       prdata = 32'd0;
        endcase
    end

    // stage enables, each stage loads when its slot frees up
    logic r_v1;
    logic r_v2;
    logic en1;
    logic en2;
    logic in_acc;

    assign en2             = !r_v2 || i_m_axis_tready;
    assign en1             = !r_v1 || en2;
    assign o_s_axis_tready = en1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // unpack the input item
    t_mv   in_cells [CELL_COUNT];
    t_temp in_temp;

    always_comb begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            in_cells[i] = i_s_axis_tdata[i*MV_W +: MV_W];
        end
    end
    assign in_temp = t_temp'(i_s_axis_tdata[CELL_COUNT*MV_W +: TEMP_W]);

    // lowest voltage compare tree, capped at the search start
    t_mv m01;
    t_mv m23;
    t_mv m45;
    t_mv in_lowest;

    assign m01       = min_mv(in_cells[0], in_cells[1]);
    assign m23       = min_mv(in_cells[2], in_cells[3]);
    assign m45       = min_mv(in_cells[4], in_cells[5]);
    assign in_lowest = min_mv(min_mv(m01, m23), min_mv(m45, MIN_SEARCH_START_MV));

    // stage one: cells, minimum and temperature window
    t_mv  r_cells [CELL_COUNT];
    t_mv  r_lowest;
    logic r_temp_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cells   <= in_cells;
            r_lowest  <= in_lowest;
            r_temp_ok <= (in_temp >= r_temp_low) && (in_temp <= r_temp_high);
        end
    end

    // candidate lanes, one per cell
    t_lane_cfg             lane_cfg;
    logic [CELL_COUNT-1:0] cand;

    assign lane_cfg.diff_mv  = r_diff_mv;
    assign lane_cfg.start_mv = r_start_mv;

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_lane
        cbs_lane u_lane (
            .i_cell_mv   (r_cells[g]),
            .i_lowest_mv (r_lowest),
            .i_temp_ok   (r_temp_ok),
            .i_cfg       (lane_cfg),
            .o_cand      (cand[g])
        );
    end

    // merge lanes into the final mask
    logic [CELL_COUNT-1:0] n_mask;
    logic [7:0]            n_bank1;
    logic [7:0]            n_bank2;

    cbs_merge u_merge (
        .i_cells (r_cells),
        .i_cand  (cand),
        .o_mask  (n_mask),
        .o_bank1 (n_bank1),
        .o_bank2 (n_bank2)
    );

    // stage two: output register
    logic [CELL_COUNT-1:0] r_mask;
    logic [7:0]            r_bank1;
    logic [7:0]            r_bank2;
    t_mv                   r_out_lowest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_mask       <= n_mask;
            r_bank1      <= n_bank1;
            r_bank2      <= n_bank2;
            r_out_lowest <= r_lowest;
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = {5'd0, r_out_lowest, r_bank2, r_bank1, r_mask};

    // checks
`include "cell_balance_select_macros.svh"

    `CBS_ASSERT(a_no_adjacent, r_v2 |-> ((r_mask & (r_mask >> 1)) == 6'd0), "adjacent cells both balanced")
    `CBS_ASSERT(a_lowest_cap, r_v2 |-> (r_out_lowest <= MIN_SEARCH_START_MV), "minimum above search start")
    `CBS_ASSERT(a_bank_unused, r_v2 |-> (((r_bank1 | r_bank2) & 8'hEC) == 8'd0), "unused balance bits set")
    `CBS_ASSERT(a_accept_loads, in_acc |=> r_v1, "accepted item not held in stage one")
    `CBS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_v1 && !r_v2), "pipeline not empty after reset")

endmodule

`default_nettype wire

### test/tb_cell_balance_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cell_balance_select
// stream-level test of the six-cell passive balancing selector
// ----------------------------------------------------------------------------
// Snapshots of six cell voltages and a pack temperature are queued by the
// stimulus process and driven into the input stream with random gaps. Each
// accepted snapshot is run through a local model of the selection (lowest
// cell, temperature window, difference and start thresholds, pair thinning)
// and the expected result waits in order until the output stream delivers
// it. The output side stalls at random and once holds off long enough to
// back the pipeline up. Thresholds are rewritten over APB between phases,
// only when nothing is in flight, covering defaults, extremes, an inverted
// temperature window and random settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cell_balance_select;
    import cbs_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 33;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [5:0] mask;
        logic [7:0] bank1;
        logic [7:0] bank2;
        t_mv        lowest;
    } t_balance;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // tdata from bit 0: cell0_mv[13] .. cell5_mv[13], pack_temp_c[8], pad[2]
    logic [87:0] i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // tdata from bit 0: balance_mask[6], bank1_bits[8], bank2_bits[8],
    // lowest_mv[13], pad[5]
    logic [39:0] o_m_axis_tdata;

    // local copy of the threshold registers
    t_temp cfg_temp_lo = RST_TEMP_LOW;
    t_temp cfg_temp_hi = RST_TEMP_HIGH;
    t_mv   cfg_diff    = RST_DIFF_MV;
    t_mv   cfg_start   = RST_START_MV;

    logic [87:0] snapshot_q [$];
    t_balance    balance_due_q [$];

    int items_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // stretch of items with no idling on either side
    wire steady = (items_sent >= 600) && (items_sent < 760);

    cell_balance_select DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // expected selection for one snapshot under the current thresholds
    function automatic t_balance predict_balance(input logic [87:0] word);
        t_mv        v [CELL_COUNT];
        t_mv        lowest;
        t_temp      temp;
        logic       warm_ok;
        logic [5:0] pick;
        t_balance   r;
        int         i;
        lowest = MIN_SEARCH_START_MV;
        temp   = word[78 +: 8];
        for (i = 0; i < CELL_COUNT; i++) begin
            v[i] = word[13*i +: 13];
            if (v[i] < lowest)
                lowest = v[i];
        end
        warm_ok = (temp >= cfg_temp_lo) && (temp <= cfg_temp_hi);
        for (i = 0; i < CELL_COUNT; i++)
            pick[i] = warm_ok && ((v[i] - lowest) >= cfg_diff) && (v[i] >= cfg_start);
        // thin adjacent picks, the lower-voltage cell of a pair gives way, the upper one on a tie
        for (i = 0; i < CELL_COUNT - 1; i++) begin
            if (pick[i] && pick[i+1]) begin
                if (v[i] < v[i+1])
                    pick[i] = 1'b0;
                else
                    pick[i+1] = 1'b0;
            end
        end
        r.mask   = pick;
        r.bank1  = {3'b000, pick[2], 2'b00, pick[1], pick[0]};
        r.bank2  = {3'b000, pick[5], 2'b00, pick[4], pick[3]};
        r.lowest = lowest;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        if (mismatch_count < REPORT_MAX)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
        mismatch_count++;
    endtask

    // compare one output item with the oldest expectation
    task automatic check_balance(input logic [39:0] word);
        t_balance want;
        if (balance_due_q.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
                $display("[%0t] unexpected output item %h", $realtime, word);
            mismatch_count++;
        end else begin
            want = balance_due_q.pop_front();
            if (word[5:0] !== want.mask)
                note_mismatch("balance_mask", want.mask, word[5:0]);
            if (word[13:6] !== want.bank1)
                note_mismatch("bank1_bits", want.bank1, word[13:6]);
            if (word[21:14] !== want.bank2)
                note_mismatch("bank2_bits", want.bank2, word[21:14]);
            if (word[34:22] !== want.lowest)
                note_mismatch("lowest_mv", want.lowest, word[34:22]);
        end
    endtask

    // input side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                balance_due_q.push_back(predict_balance(i_s_axis_tdata));
                items_sent <= items_sent + 1;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (snapshot_q.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= snapshot_q.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // output side monitor with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_balance(o_m_axis_tdata);
            if (hold_left != 0)
                i_m_axis_tready <= 1'b0;
            else
                i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apb write: setup cycle then access cycle
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP_LOW:  cfg_temp_lo = value[7:0];
            REG_TEMP_HIGH: cfg_temp_hi = value[7:0];
            REG_DIFF_MV:   cfg_diff    = value[12:0];
            REG_START_MV:  cfg_start   = value[12:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_temp lo, input t_temp hi,
                                  input t_mv diff, input t_mv start);
        write_register(REG_TEMP_LOW,  {{24{lo[7]}}, lo});
        write_register(REG_TEMP_HIGH, {{24{hi[7]}}, hi});
        write_register(REG_DIFF_MV,   {19'd0, diff});
        write_register(REG_START_MV,  {19'd0, start});
    endtask

    // wait until every queued item has gone through and come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (snapshot_q.size() != 0 || i_s_axis_tvalid || balance_due_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_snapshot(input t_mv c0, input t_mv c1, input t_mv c2,
                                  input t_mv c3, input t_mv c4, input t_mv c5,
                                  input t_temp temp);
        snapshot_q.push_back({2'b00, temp, c5, c4, c3, c2, c1, c0});
    endtask

    // mostly a realistic pack, sometimes raw noise over the full ranges
    task automatic queue_random(input int count);
        t_mv   c [CELL_COUNT];
        t_temp temp;
        int    base;
        int    n;
        int    i;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 2) begin
                for (i = 0; i < CELL_COUNT; i++)
                    c[i] = t_mv'($urandom());
                temp = t_temp'($urandom());
            end else begin
                base = int'($urandom_range(2900, 4300));
                for (i = 0; i < CELL_COUNT; i++) begin
                    if (i != 0 && $urandom_range(0, 3) == 0)
                        c[i] = c[i-1];
                    else
                        c[i] = t_mv'(base + int'($urandom_range(0, 80)));
                end
                if ($urandom_range(0, 9) == 0)
                    c[$urandom_range(0, CELL_COUNT - 1)] = t_mv'($urandom_range(4950, 8191));
                temp = t_temp'(int'($urandom_range(0, 75)) - 15);
            end
            queue_snapshot(c[0], c[1], c[2], c[3], c[4], c[5], temp);
        end
    endtask

    // random thresholds, mostly near a usable window
    task automatic apply_random_settings();
        t_temp lo;
        t_temp hi;
        t_mv   diff;
        t_mv   start;
        if ($urandom_range(0, 3) == 0) begin
            lo = t_temp'($urandom());
            hi = t_temp'($urandom());
        end else begin
            lo = t_temp'(int'($urandom_range(0, 40)) - 20);
            hi = t_temp'($urandom_range(20, 70));
        end
        diff  = ($urandom_range(0, 3) == 0) ? t_mv'($urandom()) : t_mv'($urandom_range(0, 120));
        start = ($urandom_range(0, 3) == 0) ? t_mv'($urandom())
                                             : t_mv'($urandom_range(2800, 4300));
        apply_settings(lo, hi, diff, start);
    endtask

    initial begin
        int p;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: extremes, window edges, threshold edges, ties
        queue_snapshot(0, 0, 0, 0, 0, 0, 0);
        queue_snapshot(8191, 8191, 8191, 8191, 8191, 8191, 20);
        queue_snapshot(8191, 8191, 8191, 8191, 8191, 8191, 127);
        queue_snapshot(3400, 3500, 3420, 3600, 3450, 3700, -128);
        queue_snapshot(3400, 3500, 3420, 3600, 3450, 3700, -1);
        queue_snapshot(3400, 3500, 3420, 3600, 3450, 3700, 0);
        queue_snapshot(3400, 3500, 3420, 3600, 3450, 3700, 45);
        queue_snapshot(3400, 3500, 3420, 3600, 3450, 3700, 46);
        queue_snapshot(3400, 3420, 3440, 3460, 3480, 3500, 25);
        queue_snapshot(3500, 3480, 3460, 3440, 3420, 3400, 25);
        queue_snapshot(3500, 3500, 3500, 3500, 3500, 3300, 25);
        queue_snapshot(5100, 5200, 5300, 5400, 5500, 5600, 25);
        queue_snapshot(5000, 5100, 5000, 5100, 5000, 5100, 25);
        queue_snapshot(3380, 3400, 3380, 3399, 3380, 3420, 25);
        queue_snapshot(3400, 3420, 3400, 3419, 3400, 3421, 25);
        queue_snapshot(3900, 3400, 3900, 3400, 3900, 3400, 25);
        queue_snapshot(4200, 4100, 4150, 4150, 4000, 3950, 30);
        queue_random(100);
        wait_idle();

        // widest window, zero thresholds: every cell qualifies
        apply_settings(-128, 127, 0, 0);
        queue_snapshot(0, 0, 0, 0, 0, 0, -128);
        queue_snapshot(8191, 0, 8191, 0, 8191, 0, 127);
        queue_snapshot(1, 2, 3, 4, 5, 6, 0);
        queue_random(80);
        wait_idle();

        // inverted window: nothing may balance
        apply_settings(127, -128, 20, 3400);
        queue_snapshot(3400, 3900, 3400, 3900, 3400, 3900, 0);
        queue_snapshot(3400, 3900, 3400, 3900, 3400, 3900, 127);
        queue_snapshot(3400, 3900, 3400, 3900, 3400, 3900, -128);
        queue_random(60);
        wait_idle();

        // top thresholds: only a full-scale cell over a zero cell qualifies
        apply_settings(-40, 80, 8191, 8191);
        queue_snapshot(0, 8191, 0, 8191, 0, 8191, 10);
        queue_snapshot(8191, 8191, 8191, 8191, 8191, 0, 10);
        queue_snapshot(8191, 8190, 8191, 8190, 8191, 1, 10);
        queue_random(60);
        wait_idle();

        // single-degree window
        apply_settings(25, 25, 10, 3000);
        queue_random(80);
        wait_idle();

        for (p = 0; p < 7; p++) begin
            apply_random_settings();
            queue_random(85);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/cbs_pkg.sv
rtl/core/cbs_lane.sv
rtl/core/cbs_merge.sv
rtl/core/cell_balance_select.sv
test/tb_cell_balance_select.sv
